// ===== hw/rtl/ttst_pkg.sv =====
// shared types and constants of the timed task slot table
`default_nettype none

package ttst_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_FIRE       = 8;
    localparam int FIRE_W         = $clog2(MAX_FIRE + 1);

    // result kinds
    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    // request function codes
    localparam logic FUNC_SCHEDULE = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    // one stored task
    typedef struct packed {
        logic [7:0]  pin;
        logic [31:0] start;
        logic [7:0]  value;
        logic        value2;
        logic [3:0]  action;
        logic        is_virtual;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttst_if.sv =====
// request and result channel interfaces of the timed task slot table
`default_nettype none

interface ttst_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  pin;
    logic        is_virtual;
    logic [3:0]  action;
    logic [7:0]  value;
    logic        value2;
    logic [31:0] time_value;

    modport source (
        output valid, func, pin, is_virtual, action, value, value2, time_value,
        input  ready
    );
    modport sink (
        input  valid, func, pin, is_virtual, action, value, value2, time_value,
        output ready
    );
endinterface

interface ttst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [7:0]  fired_pin;
    logic        fired_virtual;
    logic [3:0]  fired_action;
    logic [7:0]  fired_value;
    logic        fired_value2;
    logic        any_fired;
    logic        last;

    modport source (
        output valid, kind, slot, fired_pin, fired_virtual, fired_action,
               fired_value, fired_value2, any_fired, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, fired_pin, fired_virtual, fired_action,
               fired_value, fired_value2, any_fired, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/ttst_entry_mem.sv =====
// task entry memory, one write port and one registered read port
`default_nettype none

module ttst_entry_mem #(
    parameter int DEPTH = ttst_pkg::TASK_SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire ttst_pkg::entry_t wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output ttst_pkg::entry_t      rd_data
);

    ttst_pkg::entry_t mem [DEPTH];
    ttst_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/timed_task_slot_table_top.sv =====
// top level of the timed task slot table
// usage
//   req carries one request per transfer: func 0 schedules a one-shot task in the
//   lowest free slot, func 1 is a time tick carrying the current time
//   rsp carries results; a schedule gives one result (slot granted or table
//   full), a tick gives one result per fired task in slot order and then a
//   tick finished summary; last marks the final result of each request
// processing
//   one request is worked on at a time; a schedule passes through the summary
//   state to the output register; a tick walks the slots one at a time through
//   the entry memory: a free slot is skipped, a pending slot is read and then
//   time compared, and a summary follows; the walk ends early once MAX_FIRE
//   tasks have fired; the single read port of the entry memory is why the
//   slots are walked one at a time
// reset
//   every slot is free right after reset; pending flags are flops cleared
//   by rst_n, the entry memory itself needs no clearing pass
// stall
//   results go through an output register; a stalled rsp holds the walk on
//   its next result; a new request is taken once the final one is registered
`default_nettype none

module timed_task_slot_table_top #(
    parameter int TASK_SLOTS = ttst_pkg::TASK_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ttst_req_if.sink  req,
    ttst_rsp_if.source rsp
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

    // walk states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [ttst_pkg::FIRE_W-1:0] fired_reg, fired_next;
    logic [31:0]           time_reg, time_next;
    logic [1:0]            kind_reg, kind_next;
    logic [2:0]            slot_reg, slot_next;
    logic [TASK_SLOTS-1:0] pending_reg, pending_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic [2:0]            out_slot_reg, out_slot_next;
    logic [7:0]            out_pin_reg, out_pin_next;
    logic                  out_virtual_reg, out_virtual_next;
    logic [3:0]            out_action_reg, out_action_next;
    logic [7:0]            out_value_reg, out_value_next;
    logic                  out_value2_reg, out_value2_next;
    logic                  out_any_reg, out_any_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic [SLOT_W-1:0]     scan_idx;
    logic [TASK_SLOTS-1:0] free_vec;
    logic [TASK_SLOTS-1:0] free_oh;
    logic [SLOT_W-1:0]     free_idx;
    logic                  table_full;
    logic                  new_pending;

    logic                  mem_wr_en;
    ttst_pkg::entry_t      mem_wr_data;
    logic                  mem_rd_en;
    ttst_pkg::entry_t      mem_rd_data;
    logic                  due;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_idx = scan_reg[SLOT_W-1:0];

    // lowest free slot: isolate lowest set bit, then encode
    assign free_vec   = ~pending_reg;
    assign free_oh    = free_vec & (~free_vec + TASK_SLOTS'(1));
    assign table_full = &pending_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (free_oh[i])
            begin
                free_idx = free_idx | SLOT_W'(i);
            end
        end
    end

    // a pin task with pin zero is stored but never becomes pending
    assign new_pending = req.is_virtual || (req.pin != 8'd0);

    always_comb
    begin
        mem_wr_data.pin        = req.is_virtual ? 8'd0 : req.pin;
        mem_wr_data.start      = req.time_value;
        mem_wr_data.value      = req.value;
        mem_wr_data.value2     = req.is_virtual ? req.value2 : 1'b0;
        mem_wr_data.action     = req.action;
        mem_wr_data.is_virtual = req.is_virtual;
    end

    assign mem_wr_en = accept && (req.func == ttst_pkg::FUNC_SCHEDULE) && !table_full;
    assign due       = time_reg >= mem_rd_data.start;

    ttst_entry_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (SLOT_W)
    ) u_entry_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (free_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx),
        .rd_data (mem_rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        fired_next   = fired_reg;
        time_next    = time_reg;
        kind_next    = kind_reg;
        slot_next    = slot_reg;
        pending_next = pending_reg;
        mem_rd_en    = 1'b0;

        out_valid_next   = rsp.ready ? 1'b0 : out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_slot_next    = out_slot_reg;
        out_pin_next     = out_pin_reg;
        out_virtual_next = out_virtual_reg;
        out_action_next  = out_action_reg;
        out_value_next   = out_value_reg;
        out_value2_next  = out_value2_reg;
        out_any_next     = out_any_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    time_next  = req.time_value;
                    scan_next  = '0;
                    fired_next = '0;
                    slot_next  = 3'd0;
                    if (req.func == ttst_pkg::FUNC_SCHEDULE)
                    begin
                        state_next = ST_SUM;
                        if (table_full)
                        begin
                            kind_next = ttst_pkg::KIND_FULL;
                        end
                        else
                        begin
                            kind_next              = ttst_pkg::KIND_GRANT;
                            slot_next              = 3'(free_idx);
                            pending_next[free_idx] = new_pending;
                        end
                    end
                    else
                    begin
                        kind_next  = ttst_pkg::KIND_FINISH;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                priority if (scan_reg == CNT_W'(TASK_SLOTS) ||
                             fired_reg == ttst_pkg::FIRE_W'(ttst_pkg::MAX_FIRE))
                begin
                    state_next = ST_SUM;
                end
                else if (pending_reg[scan_idx])
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_EVAL;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_EVAL:
            begin
                priority if (!due)
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_kind_next          = ttst_pkg::KIND_FIRE;
                    out_slot_next          = 3'(scan_idx);
                    out_pin_next           = mem_rd_data.pin;
                    out_virtual_next       = mem_rd_data.is_virtual;
                    out_action_next        = mem_rd_data.action;
                    out_value_next         = mem_rd_data.value;
                    out_value2_next        = mem_rd_data.value2;
                    out_any_next           = 1'b0;
                    out_last_next          = 1'b0;
                    pending_next[scan_idx] = 1'b0;
                    fired_next             = fired_reg + ttst_pkg::FIRE_W'(1);
                    scan_next              = scan_reg + CNT_W'(1);
                    state_next             = ST_READ;
                end
                else
                begin
                    // hold the read data until the output register frees up
                    state_next = ST_EVAL;
                end
            end

            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = kind_reg;
                    out_slot_next    = slot_reg;
                    out_pin_next     = 8'd0;
                    out_virtual_next = 1'b0;
                    out_action_next  = 4'd0;
                    out_value_next   = 8'd0;
                    out_value2_next  = 1'b0;
                    out_any_next     = (kind_reg == ttst_pkg::KIND_FINISH) && (fired_reg != '0);
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            fired_reg     <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            fired_reg     <= fired_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        time_reg        <= time_next;
        kind_reg        <= kind_next;
        slot_reg        <= slot_next;
        out_kind_reg    <= out_kind_next;
        out_slot_reg    <= out_slot_next;
        out_pin_reg     <= out_pin_next;
        out_virtual_reg <= out_virtual_next;
        out_action_reg  <= out_action_next;
        out_value_reg   <= out_value_next;
        out_value2_reg  <= out_value2_next;
        out_any_reg     <= out_any_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.fired_pin     = out_pin_reg;
    assign rsp.fired_virtual = out_virtual_reg;
    assign rsp.fired_action  = out_action_reg;
    assign rsp.fired_value   = out_value_reg;
    assign rsp.fired_value2  = out_value2_reg;
    assign rsp.any_fired     = out_any_reg;
    assign rsp.last          = out_last_reg;

endmodule

`default_nettype wire

// ===== verif/timed_task_slot_table_top_tb.sv =====
// self-checking testbench for the timed task slot table: scheduling, ticks, table full, stalls
`default_nettype none

module timed_task_slot_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_SLOTS  = ttst_pkg::TASK_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 300;
    // a tick walks the slots one at a time
    localparam int TAIL_CYCLES = 2 * (2 * TASK_SLOTS + 2) + 4;
    localparam int RANDOM_ITEMS = 450;

    // short local names for the request function codes
    localparam logic FN_SCHED = ttst_pkg::FUNC_SCHEDULE;
    localparam logic FN_TICK  = ttst_pkg::FUNC_TICK;

    // how the two sides pace themselves while an item is in flight
    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH,
        PACE_HOLD
    } pace_t;

    typedef struct {
        logic        func;
        logic [7:0]  pin;
        logic        is_virtual;
        logic [3:0]  action;
        logic [7:0]  value;
        logic        value2;
        logic [31:0] time_value;
        pace_t       pace;
    } request_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic [7:0] fired_pin;
        logic       fired_virtual;
        logic [3:0] fired_action;
        logic [7:0] fired_value;
        logic       fired_value2;
        logic       any_fired;
        logic       last;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ttst_req_if req_ch ();
    ttst_rsp_if rsp_ch ();

    timed_task_slot_table_top #(
        .TASK_SLOTS (TASK_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // requests waiting to be offered, and results the table should give back
    request_t      request_q[$];
    table_result_t due_results[$];

    // shadow copy of the slot table
    ttst_pkg::entry_t slot_entry[TASK_SLOTS];
    logic             slot_done[TASK_SLOTS];

    request_t offered;
    pace_t    pace_now;
    int       hold_left;
    bit       hold_used;
    int       cycle_count;
    int       fail_count;

    // tallies for the closing summary
    int grant_count;
    int full_count;
    int fire_count;
    int tick_count;

    function automatic bit slot_occupied(int s);
        // a pin task with pin zero is stored but never occupies its slot
        return !slot_done[s] && (slot_entry[s].is_virtual || slot_entry[s].pin != 8'd0);
    endfunction

    // work out every result one accepted request causes and update the shadow table
    function automatic void predict_outcome(request_t it);
        table_result_t r;
        int            fired;
        bit            placed;
        r      = '0;
        fired  = 0;
        placed = 1'b0;
        if (it.func == FN_SCHED)
        begin
            // lowest free slot wins
            for (int s = 0; s < TASK_SLOTS && !placed; s++)
            begin
                if (!slot_occupied(s))
                begin
                    slot_entry[s].pin        = it.is_virtual ? 8'd0 : it.pin;
                    slot_entry[s].start      = it.time_value;
                    slot_entry[s].value      = it.value;
                    slot_entry[s].value2     = it.is_virtual ? it.value2 : 1'b0;
                    slot_entry[s].action     = it.action;
                    slot_entry[s].is_virtual = it.is_virtual;
                    slot_done[s]             = 1'b0;
                    r.kind = ttst_pkg::KIND_GRANT;
                    r.slot = 3'(s);
                    placed = 1'b1;
                    grant_count++;
                end
            end
            if (!placed)
            begin
                r.kind = ttst_pkg::KIND_FULL;
                full_count++;
            end
            r.last = 1'b1;
            due_results.push_back(r);
        end
        else
        begin
            tick_count++;
            // plain unsigned due test, no wrap handling
            for (int s = 0; s < TASK_SLOTS && fired < ttst_pkg::MAX_FIRE; s++)
            begin
                if (slot_occupied(s) && it.time_value >= slot_entry[s].start)
                begin
                    r               = '0;
                    r.kind          = ttst_pkg::KIND_FIRE;
                    r.slot          = 3'(s);
                    r.fired_pin     = slot_entry[s].pin;
                    r.fired_virtual = slot_entry[s].is_virtual;
                    r.fired_action  = slot_entry[s].action;
                    r.fired_value   = slot_entry[s].value;
                    r.fired_value2  = slot_entry[s].value2;
                    due_results.push_back(r);
                    slot_done[s] = 1'b1;
                    fired++;
                    fire_count++;
                end
            end
            r           = '0;
            r.kind      = ttst_pkg::KIND_FINISH;
            r.any_fired = (fired > 0);
            r.last      = 1'b1;
            due_results.push_back(r);
        end
    endfunction

    function automatic request_t make_request(logic func, logic [7:0] pin, logic is_virtual,
                                              logic [3:0] action, logic [7:0] value,
                                              logic value2, logic [31:0] time_value,
                                              pace_t pace);
        request_t it;
        it.func       = func;
        it.pin        = pin;
        it.is_virtual = is_virtual;
        it.action     = action;
        it.value      = value;
        it.value2     = value2;
        it.time_value = time_value;
        it.pace       = pace;
        return it;
    endfunction

    function automatic bit sender_idles(pace_t p);
        case (p)
            PACE_SEND_IDLE: return ($urandom_range(0, 99) < 63);
            PACE_BOTH:      return ($urandom_range(0, 99) < 9);
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls(pace_t p);
        case (p)
            PACE_RECV_STALL: return ($urandom_range(0, 99) < 63);
            PACE_BOTH:       return ($urandom_range(0, 99) < 9);
            default:         return 1'b0;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // driver: predicts on each accepted transfer, then offers the next pending request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.func       <= FN_SCHED;
            req_ch.pin        <= 8'd0;
            req_ch.is_virtual <= 1'b0;
            req_ch.action     <= 4'd0;
            req_ch.value      <= 8'd0;
            req_ch.value2     <= 1'b0;
            req_ch.time_value <= 32'd0;
            pace_now          <= PACE_FREE;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_outcome(offered);
                pace_now <= offered.pace;
            end
            // a new request may be offered once the current one is taken or none is up
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_q.size() != 0 && !sender_idles(request_q[0].pace))
                begin
                    offered            = request_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.func       <= offered.func;
                    req_ch.pin        <= offered.pin;
                    req_ch.is_virtual <= offered.is_virtual;
                    req_ch.action     <= offered.action;
                    req_ch.value      <= offered.value;
                    req_ch.value2     <= offered.value2;
                    req_ch.time_value <= offered.time_value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once when the hold phase begins
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && pace_now == PACE_HOLD)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        table_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t ns: result with none expected, kind %0d slot %0d",
                             $time, rsp_ch.kind, rsp_ch.slot);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
                    check_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
                    check_field("fired_pin", 32'(want.fired_pin), 32'(rsp_ch.fired_pin));
                    check_field("fired_virtual", 32'(want.fired_virtual),
                                32'(rsp_ch.fired_virtual));
                    check_field("fired_action", 32'(want.fired_action),
                                32'(rsp_ch.fired_action));
                    check_field("fired_value", 32'(want.fired_value),
                                32'(rsp_ch.fired_value));
                    check_field("fired_value2", 32'(want.fired_value2),
                                32'(rsp_ch.fired_value2));
                    check_field("any_fired", 32'(want.any_fired), 32'(rsp_ch.any_fired));
                    check_field("last", 32'(want.last), 32'(rsp_ch.last));
                end
            end
            rsp_ch.ready <= (hold_left == 0) && !receiver_stalls(pace_now);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, due_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] now;
        pace_t       pace;
        int          roll;
        request_t    it;

        // every input known from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FN_SCHED;
        req_ch.pin        = 8'd0;
        req_ch.is_virtual = 1'b0;
        req_ch.action     = 4'd0;
        req_ch.value      = 8'd0;
        req_ch.value2     = 1'b0;
        req_ch.time_value = 32'd0;
        rsp_ch.ready      = 1'b0;
        cycle_count       = 0;
        fail_count        = 0;
        grant_count       = 0;
        full_count        = 0;
        fire_count        = 0;
        tick_count        = 0;
        for (int s = 0; s < TASK_SLOTS; s++)
        begin
            slot_entry[s] = '0;
            slot_done[s]  = 1'b0;
        end

        // directed part
        // tick on an empty table
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0, 32'd0,
                                         PACE_FREE));
        // pin task at the field maxima, value2 must be dropped
        request_q.push_back(make_request(FN_SCHED, 8'hFF, 1'b0, 4'hF, 8'hFF, 1'b1, 32'd0,
                                         PACE_FREE));
        // virtual task, pin must be dropped
        request_q.push_back(make_request(FN_SCHED, 8'hAA, 1'b1, 4'd0, 8'd0, 1'b1, 32'd5,
                                         PACE_FREE));
        // pin zero: granted but the slot stays free, so the next one reuses it
        request_q.push_back(make_request(FN_SCHED, 8'd0, 1'b0, 4'h5, 8'h55, 1'b0, 32'd0,
                                         PACE_FREE));
        request_q.push_back(make_request(FN_SCHED, 8'd1, 1'b0, 4'hA, 8'hAA, 1'b0,
                                         32'hFFFF_FFFF, PACE_FREE));
        // fill the rest of the table, then one more for the full answer
        for (int k = 0; k < TASK_SLOTS - 3; k++)
            request_q.push_back(make_request(FN_SCHED, 8'(k + 2), 1'(k % 2), 4'(k),
                                             8'(k * 37), 1'b1, 32'(10 * k), PACE_FREE));
        request_q.push_back(make_request(FN_SCHED, 8'h80, 1'b1, 4'h3, 8'h0F, 1'b0, 32'd1,
                                         PACE_FREE));
        // tick just below a start time, exactly on it, then near the top of the range
        request_q.push_back(make_request(FN_TICK, 8'hFF, 1'b1, 4'hF, 8'hFF, 1'b1, 32'd4,
                                         PACE_FREE));
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0, 32'd5,
                                         PACE_FREE));
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0,
                                         32'hFFFF_FFFE, PACE_FREE));
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0,
                                         32'hFFFF_FFFF, PACE_FREE));
        // nothing left, then reuse of freed slots
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0, 32'd0,
                                         PACE_FREE));
        request_q.push_back(make_request(FN_SCHED, 8'h7F, 1'b0, 4'h9, 8'h81, 1'b1, 32'd0,
                                         PACE_FREE));
        request_q.push_back(make_request(FN_TICK, 8'd0, 1'b0, 4'd0, 8'd0, 1'b0, 32'd0,
                                         PACE_FREE));

        // random part: mostly a running clock with near-future tasks, some noise
        now = 32'd0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case (n / 90)
                0:       pace = PACE_FREE;
                1:       pace = PACE_SEND_IDLE;
                2:       pace = PACE_RECV_STALL;
                3:       pace = PACE_BOTH;
                default: pace = PACE_HOLD;
            endcase
            roll = $urandom_range(0, 99);
            it.pace       = pace;
            it.action     = 4'($urandom);
            it.value      = 8'($urandom);
            it.value2     = 1'($urandom);
            it.is_virtual = ($urandom_range(0, 99) < 30);
            it.pin        = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (roll < 15)
            begin
                // noise: any field, any time
                it.func       = 1'($urandom);
                it.pin        = 8'($urandom);
                it.is_virtual = 1'($urandom);
                it.time_value = $urandom;
            end
            else if (roll < 62)
            begin
                it.func       = FN_SCHED;
                it.time_value = now + $urandom_range(0, 24);
            end
            else
            begin
                it.func       = FN_TICK;
                now           = now + $urandom_range(0, 8);
                it.time_value = now;
            end
            request_q.push_back(it);
        end

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything offered and taken, every result back, then a quiet tail
        while (request_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ticks, %0d fired tasks, %0d grants, %0d full answers",
                 tick_count, fire_count, grant_count, full_count);
        $display("idle, stall and long hold-off phases run; %0d mismatches", fail_count);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
